### hdl/huffman_code_table_builder_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman code table builder / encoder
// Shared property wrappers, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_TABLE_BUILDER_ENCODER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define HCTB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCTB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hctb_pkg.sv
// ----------------------------------------------------------------------------
// hctb_pkg
// Shared types and constants of the Huffman code table builder / encoder.
// ----------------------------------------------------------------------------
package hctb_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int PATH_LIMIT   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int USER_IN_W  = 4;
    localparam int DATA_OUT_W = 40;   // 32 + 6 + 1 rounded up to bytes

    localparam logic [LEN_W-1:0] PATH_LIMIT_L = LEN_W'(PATH_LIMIT);

    localparam logic ARC_LEFT  = 1'b0;
    localparam logic ARC_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_NODE   = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_EOF    = 2'd3
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic start;      // reset path to a single left branch
        logic node;       // apply a tree node
        logic lookup;     // fetch code of byte or end-of-file symbol
        logic load_out;   // move fetched code into output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register empty or draining this cycle
    } dp_status_t;

endpackage

### hdl/hctb_ctrl.sv
// ----------------------------------------------------------------------------
// hctb_ctrl
// Sequencer: accepts a transaction, issues datapath commands, waits for the
// output register on lookups.
// ----------------------------------------------------------------------------
`include "huffman_code_table_builder_encoder_unit_assert.svh"

module hctb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            cmd,
    input  hctb_pkg::dp_status_t  status,
    output hctb_pkg::ctl_cmd_t    ctl
);
    import hctb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        ctl.start    = 1'b0;
        ctl.node     = 1'b0;
        ctl.lookup   = 1'b0;
        ctl.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd_t'(cmd))
                        CMD_START:  ctl.start = 1'b1;
                        CMD_NODE:   ctl.node  = 1'b1;
                        CMD_ENCODE, CMD_EOF: begin
                            ctl.lookup = 1'b1;
                            state_next = ST_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `HCTB_ASSERT_NXT(a_lookup_waits, aclk, aresetn, ctl.lookup, state_reg == ST_LOAD, "lookup did not enter load")
    `HCTB_ASSERT_NXT(a_load_holds, aclk, aresetn, (state_reg == ST_LOAD) && !status.out_free, state_reg == ST_LOAD, "load dropped while output busy")

endmodule

### hdl/hctb_datapath.sv
// ----------------------------------------------------------------------------
// hctb_datapath
// Path register, code table memory, end-of-file code, overflow flag and the
// output register.
// ----------------------------------------------------------------------------
`include "huffman_code_table_builder_encoder_unit_assert.svh"

module hctb_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hctb_pkg::ctl_cmd_t                   ctl,
    output hctb_pkg::dp_status_t                 status,
    input  logic [1:0]                           cmd,
    input  logic                                 is_leaf,
    input  logic                                 is_eof,
    input  logic [hctb_pkg::SYM_W-1:0]           symbol,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hctb_pkg::CODE_W-1:0]          code,
    output logic [hctb_pkg::LEN_W-1:0]           code_len,
    output logic                                 overflow
);
    import hctb_pkg::*;

    localparam int DEPTH = 1 << SYM_W;
    localparam int ENT_W = LEN_W + CODE_W;

    // count of trailing ones, 0..32
    function automatic logic [LEN_W-1:0] trailing_ones(input logic [CODE_W-1:0] v);
        logic [LEN_W-1:0] n;
        logic             hit;
        n   = '0;
        hit = 1'b0;
        for (int i = 0; i < CODE_W; i++) begin
            if (!hit) begin
                if (v[i] == ARC_RIGHT) begin
                    n = n + LEN_W'(1);
                end else begin
                    hit = 1'b1;
                end
            end
        end
        return n;
    endfunction

    logic [ENT_W-1:0]  mem [DEPTH];
    logic [ENT_W-1:0]  rd_data_reg;
    logic              sel_eof_reg;

    logic [CODE_W-1:0] path_bits_reg, path_bits_next;
    logic [LEN_W-1:0]  path_len_reg,  path_len_next;
    logic [CODE_W-1:0] end_bits_reg;
    logic [LEN_W-1:0]  end_len_reg;
    logic              ovf_reg, ovf_next;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_ovf_reg;

    logic [LEN_W-1:0]  strip;
    logic [CODE_W-1:0] bumped;
    logic              leaf_byte;
    logic              leaf_end;

    assign leaf_byte = ctl.node && is_leaf && !is_eof;
    assign leaf_end  = ctl.node && is_leaf && is_eof;

    // adding one clears the trailing ones and turns the last 0 into a 1;
    // shifting drops the cleared positions
    assign strip  = trailing_ones(path_bits_reg);
    assign bumped = path_bits_reg + CODE_W'(1);

    always_comb begin
        path_bits_next = path_bits_reg;
        path_len_next  = path_len_reg;
        ovf_next       = ovf_reg;
        if (ctl.start) begin
            path_bits_next = {{(CODE_W-1){1'b0}}, ARC_LEFT};
            path_len_next  = LEN_W'(1);
        end else if (ctl.node) begin
            if (is_leaf) begin
                if (path_len_reg != '0) begin
                    // a path of right branches only leaves an empty path
                    path_bits_next = (strip == path_len_reg) ? '0 : (bumped >> strip);
                    path_len_next  = path_len_reg - strip;
                end
            end else if (path_len_reg >= PATH_LIMIT_L) begin
                ovf_next = 1'b1;
            end else begin
                path_bits_next = {path_bits_reg[CODE_W-2:0], ARC_LEFT};
                path_len_next  = path_len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_bits_reg <= '0;
            path_len_reg  <= LEN_W'(1);
            end_bits_reg  <= '0;
            end_len_reg   <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            path_bits_reg <= path_bits_next;
            path_len_reg  <= path_len_next;
            ovf_reg       <= ovf_next;
            if (leaf_end) begin
                end_bits_reg <= path_bits_reg;
                end_len_reg  <= path_len_reg;
            end
        end
    end

    // code table, no reset
    always_ff @(posedge aclk) begin
        if (leaf_byte) begin
            mem[symbol] <= {path_len_reg, path_bits_reg};
        end
        if (ctl.lookup) begin
            rd_data_reg <= mem[symbol];
            sel_eof_reg <= (cmd_t'(cmd) == CMD_EOF);
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            out_ovf_reg <= ovf_reg;
            if (sel_eof_reg) begin
                out_code_reg <= end_bits_reg;
                out_len_reg  <= end_len_reg;
            end else begin
                out_code_reg <= rd_data_reg[CODE_W-1:0];
                out_len_reg  <= rd_data_reg[ENT_W-1:CODE_W];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign code     = out_code_reg;
    assign code_len = out_len_reg;
    assign overflow = out_ovf_reg;

    `HCTB_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, path_len_reg <= PATH_LIMIT_L, "path longer than limit")
    `HCTB_ASSERT_IMP(a_upper_zero, aclk, aresetn, 1'b1, (path_bits_reg >> path_len_reg) == '0, "path bits set above length")
    `HCTB_ASSERT_NXT(a_ovf_sticky, aclk, aresetn, ovf_reg, ovf_reg, "overflow flag cleared")

endmodule

### hdl/huffman_code_table_builder_encoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_table_builder_encoder_unit
// Builds a prefix code table from a preorder tree walk, then encodes bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser carries the command and node flags, s_tdata
//   the symbol. A start command resets the path; tree-node transactions in
//   preorder (root omitted) fill the code table; encode and finish commands
//   each produce one output transaction (code, length, sticky overflow).
//   Start and tree-node transactions produce no output. Encode and finish
//   register the table read, then move the result to the output register;
//   the next transaction is taken in the cycle after that move.
//   A stalled receiver holds the result in the output register; tree-node
//   transactions are still taken, and a following lookup waits in the load
//   state until the output register frees up.
//   Reset sets the path to a single 0 bit and clears the end-of-file code
//   and overflow flag; the byte table is not cleared and must be built
//   before bytes are encoded.
// ----------------------------------------------------------------------------
module huffman_code_table_builder_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] symbol
    input  logic [3:0]  s_tuser,    // [1:0] cmd, [2] is_leaf, [3] is_eof
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [31:0] code, [37:32] code_len, [38] overflow, zero pad
);
    import hctb_pkg::*;

    ctl_cmd_t          ctl;
    dp_status_t        status;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_len;
    logic              overflow;

    hctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tuser[1:0]),
        .status   (status),
        .ctl      (ctl)
    );

    hctb_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .status   (status),
        .cmd      (s_tuser[1:0]),
        .is_leaf  (s_tuser[2]),
        .is_eof   (s_tuser[3]),
        .symbol   (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .code     (code),
        .code_len (code_len),
        .overflow (overflow)
    );

    assign m_tdata = {1'b0, overflow, code_len, code};

endmodule
